/* src/cbpe_pkg.sv */
// ----------------------------------------------------------------------------
// cbpe_pkg
// Shared constants and types for the cubic Bezier point evaluator.
// ----------------------------------------------------------------------------
package cbpe_pkg;

  // Coordinate width default (signed Q12.4 at 16 bits)
  localparam int unsigned CoordWidthDef = 16;

  // Segment count is clamped to this before t is formed
  localparam int unsigned MaxSegments = 1024;

  // Input fields
  localparam int unsigned CntWidth = 11;
  localparam int unsigned InDataW  = ((2 * CntWidth + 7) / 8) * 8;

  // Curve parameter t: Q1.16, with one integer bit so that t = 1 is exact
  localparam int unsigned TFracBits = 16;
  localparam int unsigned TWidth    = TFracBits + 1;
  localparam logic [TWidth-1:0] TOne = TWidth'(1) << TFracBits;

  // t / u products (Q2.32) and Bernstein weights (Q1.48, at most 2^48)
  localparam int unsigned SqWidth     = 2 * TWidth;
  localparam int unsigned WeightWidth = 3 * TFracBits + 1;
  localparam int unsigned WLoBits     = 24;
  localparam int unsigned WHiBits     = WeightWidth - WLoBits;
  localparam int unsigned RoundBit    = 3 * TFracBits - 1;

  // Divider: quotient bits resolved per pipeline stage
  localparam int unsigned DivBitsPerStage = 3;
  localparam int unsigned DivSteps = (TWidth + DivBitsPerStage - 1) / DivBitsPerStage;

  // Configuration registers
  localparam int unsigned NumRegs  = 8;
  localparam int unsigned RegIdxW  = $clog2(NumRegs);
  localparam int unsigned NumAxes  = 2;
  localparam int unsigned NumPts   = 4;

  typedef enum logic [RegIdxW-1:0] {
    REG_START_X,
    REG_START_Y,
    REG_CTRL_A_X,
    REG_CTRL_A_Y,
    REG_CTRL_B_X,
    REG_CTRL_B_Y,
    REG_END_X,
    REG_END_Y
  } cbpe_reg_e;

endpackage

/* src/cbpe_div.sv */
// ----------------------------------------------------------------------------
// cbpe_div
// Pipelined restoring divider: t = round(index * 2^16 / count), three
// quotient bits per stage, with index and count clamping up front.
// ----------------------------------------------------------------------------
module cbpe_div
  import cbpe_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [CntWidth-1:0] idx_i,
  input  logic [CntWidth-1:0] cnt_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [TWidth-1:0]   t_o
);

  typedef struct packed {
    logic [CntWidth-1:0] rem;
    logic [TWidth-1:0]   num;
    logic [TWidth-1:0]   quo;
    logic [CntWidth-1:0] cnt;
    logic                zero;
  } div_stage_t;

  localparam int unsigned NStages = DivSteps + 1;

  div_stage_t          r_q [NStages];
  div_stage_t          prep;
  logic [NStages-1:0]  v_q;
  logic [NStages-1:0]  en;
  logic [CntWidth-1:0] cnt_sat;
  logic [CntWidth-1:0] idx_sat;

  function automatic div_stage_t div_step(div_stage_t s, int unsigned first_bit);
    logic [CntWidth:0] trial;
    div_stage_t        r;
    r = s;
    for (int unsigned b = 0; b < DivBitsPerStage; b++) begin
      if (first_bit + b < TWidth) begin
        trial = {r.rem, r.num[TWidth-1]};
        r.num = r.num << 1;
        if (trial >= {1'b0, r.cnt}) begin
          r.rem = CntWidth'(trial - {1'b0, r.cnt});
          r.quo = {r.quo[TWidth-2:0], 1'b1};
        end else begin
          r.rem = trial[CntWidth-1:0];
          r.quo = {r.quo[TWidth-2:0], 1'b0};
        end
      end
    end
    return r;
  endfunction

  // Numerator is index * 2^16 + count/2. Its bits above the quotient range
  // reduce to index/2, which is already below count, so it seeds the
  // remainder and only 17 numerator bits remain to shift through.
  always_comb begin
    cnt_sat = cnt_i;
    if (32'(cnt_i) > MaxSegments) begin
      cnt_sat = CntWidth'(MaxSegments);
    end
    idx_sat = (idx_i > cnt_sat) ? cnt_sat : idx_i;
    prep.rem  = idx_sat >> 1;
    prep.num  = {idx_sat[0], TFracBits'(cnt_sat >> 1)};
    prep.quo  = '0;
    prep.cnt  = cnt_sat;
    prep.zero = (cnt_sat == '0);
  end

  always_comb begin
    en[NStages-1] = !v_q[NStages-1] || out_ready_i;
    for (int k = NStages - 2; k >= 0; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) begin
        v_q[0] <= in_valid_i;
      end
      for (int unsigned k = 1; k < NStages; k++) begin
        if (en[k]) begin
          v_q[k] <= v_q[k-1];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      r_q[0] <= prep;
    end
    for (int unsigned k = 1; k < NStages; k++) begin
      if (en[k]) begin
        r_q[k] <= div_step(r_q[k-1], (k - 1) * DivBitsPerStage);
      end
    end
  end

  assign in_ready_o  = en[0];
  assign out_valid_o = v_q[NStages-1];
  assign t_o         = r_q[NStages-1].zero ? '0 : r_q[NStages-1].quo;

  a_t_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> t_o <= TOne)
    else $error("t above one");

  a_rem_below_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[NStages-1] && !r_q[NStages-1].zero |-> r_q[NStages-1].rem < r_q[NStages-1].cnt)
    else $error("divider remainder not below count");

endmodule

/* src/cbpe_weights.sv */
// ----------------------------------------------------------------------------
// cbpe_weights
// Two-stage Bernstein weight generator: u^3, t*u^2, t^2*u, t^3 with
// u = 1 - t. The factor of three on the inner weights is applied later.
// ----------------------------------------------------------------------------
module cbpe_weights
  import cbpe_pkg::*;
(
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [TWidth-1:0]                   t_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [NumPts-1:0][WeightWidth-1:0]  w_o
);

  localparam int unsigned ProdW = SqWidth + TWidth;

  logic [1:0]               v_q;
  logic [1:0]               en;
  logic [TWidth-1:0]        u_d;
  logic [TWidth-1:0]        t_q, u_q;
  logic [SqWidth-1:0]       tt_d, tu_d, uu_d;
  logic [SqWidth-1:0]       tt_q, tu_q, uu_q;
  logic [ProdW-1:0]         p0, p1, p2, p3;
  logic [NumPts-1:0][WeightWidth-1:0] w_q;
  logic [WeightWidth+1:0]   wsum;

  always_comb begin
    u_d  = TOne - t_i;
    tt_d = SqWidth'(t_i) * SqWidth'(t_i);
    tu_d = SqWidth'(t_i) * SqWidth'(u_d);
    uu_d = SqWidth'(u_d) * SqWidth'(u_d);
  end

  always_comb begin
    p0 = ProdW'(uu_q) * ProdW'(u_q);
    p1 = ProdW'(tu_q) * ProdW'(u_q);
    p2 = ProdW'(tu_q) * ProdW'(t_q);
    p3 = ProdW'(tt_q) * ProdW'(t_q);
  end

  assign en[1] = !v_q[1] || out_ready_i;
  assign en[0] = !v_q[0] || en[1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) begin
        v_q[0] <= in_valid_i;
      end
      if (en[1]) begin
        v_q[1] <= v_q[0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      t_q  <= t_i;
      u_q  <= u_d;
      tt_q <= tt_d;
      tu_q <= tu_d;
      uu_q <= uu_d;
    end
    if (en[1]) begin
      w_q[0] <= p0[WeightWidth-1:0];
      w_q[1] <= p1[WeightWidth-1:0];
      w_q[2] <= p2[WeightWidth-1:0];
      w_q[3] <= p3[WeightWidth-1:0];
    end
  end

  assign in_ready_o  = en[0];
  assign out_valid_o = v_q[1];
  assign w_o         = w_q;

  // Partition of unity: u^3 + 3tu^2 + 3t^2u + t^3 = (u + t)^3 = 2^48
  assign wsum = (WeightWidth+2)'(w_q[0]) + 3 * (WeightWidth+2)'(w_q[1])
              + 3 * (WeightWidth+2)'(w_q[2]) + (WeightWidth+2)'(w_q[3]);

  a_weight_sum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> wsum == ((WeightWidth+2)'(1) << (3 * TFracBits)))
    else $error("Bernstein weights do not sum to one");

endmodule

/* src/cbpe_mac.sv */
// ----------------------------------------------------------------------------
// cbpe_mac
// Weighted sum of the control points for both axes: split-weight products,
// adder stage with rounding bias, then shift, round and saturate.
// ----------------------------------------------------------------------------
module cbpe_mac
  import cbpe_pkg::*;
#(
  parameter int unsigned CoordWidth = CoordWidthDef
) (
  input  logic                                         clk_i,
  input  logic                                         rst_ni,
  input  logic                                         in_valid_i,
  output logic                                         in_ready_o,
  input  logic [NumPts-1:0][WeightWidth-1:0]           w_i,
  input  logic [NumAxes-1:0][NumPts-1:0][CoordWidth-1:0] pts_i,
  output logic                                         out_valid_o,
  input  logic                                         out_ready_i,
  output logic [NumAxes-1:0][CoordWidth-1:0]           point_o
);

  localparam int unsigned CoefW   = CoordWidth + 2;
  localparam int unsigned PhW     = CoefW + WHiBits + 1;
  localparam int unsigned PlW     = CoefW + WLoBits + 1;
  localparam int unsigned HiSumW  = PhW + 2;
  localparam int unsigned LoBase  = (PlW + 2 > RoundBit + 2) ? PlW + 2 : RoundBit + 2;
  localparam int unsigned LoSumW  = LoBase + 1;
  localparam int unsigned TotW    = ((HiSumW > LoSumW - WLoBits) ?
                                     HiSumW : LoSumW - WLoBits) + 1;
  localparam int unsigned ResW    = TotW - WLoBits;

  localparam logic signed [LoSumW-1:0] LoBias = LoSumW'(1) << RoundBit;
  localparam logic signed [ResW-1:0]   MaxV   =
    {{(ResW - CoordWidth + 1){1'b0}}, {(CoordWidth - 1){1'b1}}};
  localparam logic signed [ResW-1:0]   MinV   = ~MaxV;

  logic [2:0] v_q;
  logic [2:0] en;

  logic signed [PhW-1:0]    ph_d [NumAxes][NumPts];
  logic signed [PlW-1:0]    pl_d [NumAxes][NumPts];
  logic signed [PhW-1:0]    ph_q [NumAxes][NumPts];
  logic signed [PlW-1:0]    pl_q [NumAxes][NumPts];
  logic signed [HiSumW-1:0] hi_d [NumAxes];
  logic signed [LoSumW-1:0] lo_d [NumAxes];
  logic signed [HiSumW-1:0] hi_q [NumAxes];
  logic signed [LoSumW-1:0] lo_q [NumAxes];
  logic [NumAxes-1:0][CoordWidth-1:0] pt_d;
  logic [NumAxes-1:0][CoordWidth-1:0] pt_q;

  // Products: inner control points carry the factor of three
  always_comb begin
    logic signed [CoefW-1:0] c;
    logic signed [CoefW-1:0] pe;
    for (int unsigned a = 0; a < NumAxes; a++) begin
      for (int unsigned i = 0; i < NumPts; i++) begin
        pe = CoefW'($signed(pts_i[a][i]));
        c  = (i == 1 || i == 2) ? pe + (pe <<< 1) : pe;
        ph_d[a][i] = c * $signed({1'b0, w_i[i][WeightWidth-1:WLoBits]});
        pl_d[a][i] = c * $signed({1'b0, w_i[i][WLoBits-1:0]});
      end
    end
  end

  always_comb begin
    for (int unsigned a = 0; a < NumAxes; a++) begin
      hi_d[a] = HiSumW'(ph_q[a][0]) + HiSumW'(ph_q[a][1])
              + HiSumW'(ph_q[a][2]) + HiSumW'(ph_q[a][3]);
      lo_d[a] = LoSumW'(pl_q[a][0]) + LoSumW'(pl_q[a][1])
              + LoSumW'(pl_q[a][2]) + LoSumW'(pl_q[a][3]) + LoBias;
    end
  end

  // Floor shifts on both halves give round half up on the full sum
  always_comb begin
    logic signed [TotW-1:0] tot;
    logic signed [ResW-1:0] res;
    for (int unsigned a = 0; a < NumAxes; a++) begin
      tot = TotW'(hi_q[a]) + TotW'($signed(lo_q[a][LoSumW-1:WLoBits]));
      res = $signed(tot[TotW-1:WLoBits]);
      if (res > MaxV) begin
        pt_d[a] = MaxV[CoordWidth-1:0];
      end else if (res < MinV) begin
        pt_d[a] = MinV[CoordWidth-1:0];
      end else begin
        pt_d[a] = res[CoordWidth-1:0];
      end
    end
  end

  assign en[2] = !v_q[2] || out_ready_i;
  assign en[1] = !v_q[1] || en[2];
  assign en[0] = !v_q[0] || en[1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) begin
        v_q[0] <= in_valid_i;
      end
      if (en[1]) begin
        v_q[1] <= v_q[0];
      end
      if (en[2]) begin
        v_q[2] <= v_q[1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      ph_q <= ph_d;
      pl_q <= pl_d;
    end
    if (en[1]) begin
      hi_q <= hi_d;
      lo_q <= lo_d;
    end
    if (en[2]) begin
      pt_q <= pt_d;
    end
  end

  assign in_ready_o  = en[0];
  assign out_valid_o = v_q[2];
  assign point_o     = pt_q;

endmodule

/* src/cubic_bezier_point_eval_top.sv */
// Cubic Bezier point evaluator. Each stream transaction carries a sample
// index and a segment count; the block returns one curve point
// (1-t)^3 P0 + 3t(1-t)^2 P1 + 3t^2(1-t) P2 + t^3 P3 with t = index/count,
// rounded to the coordinate grid and saturated. A new transaction can be
// taken every clock unless back-pressure stalls the input. The pipelined
// divider forms t (three quotient bits per stage); the weight multipliers
// and the multiply, add and round stages follow. Each stage holds
// independently under output back-pressure, so bubbles are squeezed out
// before the input stalls. The user must write control points through the
// configuration port only while no transaction is in flight (not enforced).
// ----------------------------------------------------------------------------
// cubic_bezier_point_eval_top
// Top level: configuration registers, stream ports and pipeline wiring.
// ----------------------------------------------------------------------------
module cubic_bezier_point_eval_top
  import cbpe_pkg::*;
#(
  parameter int unsigned CoordWidth = CoordWidthDef
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // Configuration write port
  input  logic                  cfg_wr_en_i,
  input  logic [RegIdxW-1:0]    cfg_idx_i,
  input  logic [CoordWidth-1:0] cfg_wdata_i,
  // Input stream
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [InDataW-1:0]    s_axis_tdata,   // sample_index, segment_count
  // Output stream
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [((2 * CoordWidth + 7) / 8) * 8 - 1:0] m_axis_tdata  // point_x, point_y
);

  localparam int unsigned OutDataW = ((2 * CoordWidth + 7) / 8) * 8;

  logic [CoordWidth-1:0] cfg_q [NumRegs];

  logic [NumAxes-1:0][NumPts-1:0][CoordWidth-1:0] pts;
  logic                                div_valid, div_ready;
  logic [TWidth-1:0]                   t;
  logic                                wgt_valid, wgt_ready;
  logic [NumPts-1:0][WeightWidth-1:0]  w;
  logic [NumAxes-1:0][CoordWidth-1:0]  point;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int unsigned i = 0; i < NumRegs; i++) begin
        cfg_q[i] <= '0;
      end
    end else if (cfg_wr_en_i) begin
      cfg_q[cfg_idx_i] <= cfg_wdata_i;
    end
  end

  assign pts[0][0] = cfg_q[REG_START_X];
  assign pts[0][1] = cfg_q[REG_CTRL_A_X];
  assign pts[0][2] = cfg_q[REG_CTRL_B_X];
  assign pts[0][3] = cfg_q[REG_END_X];
  assign pts[1][0] = cfg_q[REG_START_Y];
  assign pts[1][1] = cfg_q[REG_CTRL_A_Y];
  assign pts[1][2] = cfg_q[REG_CTRL_B_Y];
  assign pts[1][3] = cfg_q[REG_END_Y];

  cbpe_div u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .idx_i       (s_axis_tdata[CntWidth-1:0]),
    .cnt_i       (s_axis_tdata[2*CntWidth-1:CntWidth]),
    .out_valid_o (div_valid),
    .out_ready_i (div_ready),
    .t_o         (t)
  );

  cbpe_weights u_weights (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (div_valid),
    .in_ready_o  (div_ready),
    .t_i         (t),
    .out_valid_o (wgt_valid),
    .out_ready_i (wgt_ready),
    .w_o         (w)
  );

  cbpe_mac #(
    .CoordWidth (CoordWidth)
  ) u_mac (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (wgt_valid),
    .in_ready_o  (wgt_ready),
    .w_i         (w),
    .pts_i       (pts),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .point_o     (point)
  );

  assign m_axis_tdata = OutDataW'({point[1], point[0]});

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the cubic Bezier point evaluator. An initial block
// loads the control points while the pipeline is empty, then queues sample
// transactions; a clocked driver and sink apply them with random gaps and
// back-pressure. Every accepted input is run through an exact fixed-point
// model of the curve, and each output point is checked against the oldest
// expected point.
// ----------------------------------------------------------------------------
module tb_top;
  import cbpe_pkg::*;

  localparam int unsigned CoordW = CoordWidthDef;
  localparam int unsigned OutDataW = ((2 * CoordW + 7) / 8) * 8;
  localparam int unsigned PipeDrain = 20;

  typedef struct packed {
    logic signed [CoordW-1:0] point_y;
    logic signed [CoordW-1:0] point_x;
  } point_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_wr_en_i = 1'b0;
  logic [RegIdxW-1:0]    cfg_idx_i = '0;
  logic [CoordW-1:0]     cfg_wdata_i = '0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [InDataW-1:0]    s_axis_tdata = '0;    // sample_index, segment_count
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OutDataW-1:0]   m_axis_tdata;         // point_x, point_y

  // control points as loaded into the block, indexed like the registers
  logic signed [CoordW-1:0] ctrl_pts [NumRegs];

  logic [InDataW-1:0] sample_q [$];
  point_t             point_q [$];
  int                 samples_owed = 0;
  int                 errors = 0;
  logic               src_fire = 1'b0;
  logic               src_gaps = 1'b1;
  logic               sink_gaps = 1'b1;

  cubic_bezier_point_eval_top #(
    .CoordWidth(CoordW)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_wr_en_i  (cfg_wr_en_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  task automatic log_mismatch(input string msg);
    errors++;
    $display("mismatch at %0t: %s", $time, msg);
  endtask

  // Weighted sum along one axis, exact, then floor((sum + 2^47) / 2^48), saturated
  function automatic logic signed [CoordW-1:0] axis_blend(input int axis,
                                                          input longint unsigned wt [4]);
    logic signed [79:0] acc;
    logic signed [79:0] coord;
    logic signed [79:0] weight;
    acc = '0;
    for (int i = 0; i < NumPts; i++) begin
      coord = ctrl_pts[i * NumAxes + axis];
      weight = wt[i];
      acc = acc + coord * weight;
    end
    acc = (acc + (80'sd1 <<< RoundBit)) >>> (3 * TFracBits);
    if (acc > 80'sd32767) acc = 80'sd32767;
    if (acc < -80'sd32768) acc = -80'sd32768;
    return acc[CoordW-1:0];
  endfunction

  function automatic point_t bezier_point(input logic [CntWidth-1:0] idx_in,
                                          input logic [CntWidth-1:0] cnt_in);
    longint unsigned idx, cnt, t, u;
    longint unsigned wt [4];
    point_t pt;
    idx = idx_in;
    cnt = cnt_in;
    if (cnt > MaxSegments) cnt = MaxSegments;
    if (idx > cnt) idx = cnt;
    t = (cnt == 0) ? 0 : (idx * 65536 + cnt / 2) / cnt;
    u = 65536 - t;
    wt[0] = u * u * u;
    wt[1] = 3 * t * u * u;
    wt[2] = 3 * t * t * u;
    wt[3] = t * t * t;
    pt.point_x = axis_blend(0, wt);
    pt.point_y = axis_blend(1, wt);
    return pt;
  endfunction

  // Source side: hold a transaction until it is taken
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || src_fire) begin
      if (sample_q.size() != 0 && !(src_gaps && $urandom_range(99) < 30)) begin
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= sample_q.pop_front();
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  always @(negedge clk_i) begin
    m_axis_tready <= rst_ni && !(sink_gaps && $urandom_range(99) < 30);
  end

  always @(posedge clk_i) begin : monitor
    point_t got;
    point_t want;
    src_fire <= rst_ni && s_axis_tvalid && s_axis_tready;
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        point_q = {point_q, bezier_point(s_axis_tdata[CntWidth-1:0],
                                         s_axis_tdata[2*CntWidth-1:CntWidth])};
        samples_owed--;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata[2*CoordW-1:0];
        if (point_q.size() == 0) begin
          log_mismatch($sformatf("unexpected point x=%0d y=%0d", got.point_x, got.point_y));
        end else begin
          want = point_q.pop_front();
          if (got.point_x !== want.point_x)
            log_mismatch($sformatf("point_x got %0d want %0d", got.point_x, want.point_x));
          if (got.point_y !== want.point_y)
            log_mismatch($sformatf("point_y got %0d want %0d", got.point_y, want.point_y));
        end
      end
    end
  end

  task automatic queue_sample(input int idx, input int cnt);
    sample_q = {sample_q, InDataW'({cnt[CntWidth-1:0], idx[CntWidth-1:0]})};
    samples_owed++;
  endtask

  task automatic queue_random(input int n);
    int cnt, idx, r;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(99);
      if (r < 10)      cnt = $urandom_range(0, 2047);
      else if (r < 40) cnt = $urandom_range(1, 16);
      else             cnt = $urandom_range(1, MaxSegments);
      if ($urandom_range(99) < 10) idx = $urandom_range(0, 2047);
      else                         idx = $urandom_range(0, cnt);
      queue_sample(idx, cnt);
    end
  endtask

  // Wait for the pipeline to empty, then let it drain a little longer
  task automatic settle();
    while (samples_owed != 0 || point_q.size() != 0) @(negedge clk_i);
    repeat (PipeDrain) @(negedge clk_i);
  endtask

  task automatic write_curve(input int x0, input int y0, input int x1, input int y1,
                             input int x2, input int y2, input int x3, input int y3);
    int vals [NumRegs];
    vals = '{x0, y0, x1, y1, x2, y2, x3, y3};
    for (int r = 0; r < NumRegs; r++) begin
      @(negedge clk_i);
      cfg_wr_en_i <= 1'b1;
      cfg_idx_i   <= cbpe_reg_e'(r);
      cfg_wdata_i <= vals[r][CoordW-1:0];
      ctrl_pts[r] = vals[r][CoordW-1:0];
    end
    @(negedge clk_i);
    cfg_wr_en_i <= 1'b0;
  endtask

  function automatic int rand_coord();
    int r;
    r = $urandom_range(99);
    if (r < 20) return -32768;
    if (r < 40) return 32767;
    return $urandom_range(0, 65535) - 32768;
  endfunction

  initial begin
    for (int r = 0; r < NumRegs; r++) ctrl_pts[r] = '0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // reset values of the control points: every point is the origin
    queue_random(10);
    settle();

    write_curve(-32768, 32767, 32767, -32768, -32768, 32767, 32767, -32768);
    queue_sample(0, 1);
    queue_sample(1, 1);
    queue_sample(0, 0);        // zero count gives the start point
    queue_sample(2047, 0);
    queue_sample(1024, 1024);
    queue_sample(2047, 2047);  // count above the maximum and index beyond it
    queue_sample(0, 2047);
    queue_sample(1025, 1025);
    queue_sample(5, 3);        // index beyond count
    queue_sample(512, 1024);
    queue_sample(1, 3);        // t rounds down
    queue_sample(2, 3);        // t rounds up
    queue_sample(1, 1024);
    queue_sample(1023, 1024);
    queue_sample(1, 2);
    queue_sample(341, 1023);
    queue_sample(1365, 1365);
    queue_sample(682, 1365);
    queue_random(200);
    settle();

    write_curve(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767);
    queue_random(150);
    settle();

    write_curve(-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768);
    queue_random(150);
    settle();

    write_curve(0, 0, 32767, 32767, -32768, -32768, 1, -1);
    queue_random(150);
    settle();

    for (int p = 0; p < 6; p++) begin
      src_gaps  = (p != 2);
      sink_gaps = (p != 2);
      write_curve(rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                  rand_coord(), rand_coord(), rand_coord(), rand_coord());
      queue_random(225);
      settle();
    end

    if (errors == 0 && point_q.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

/* cubic_bezier_point_eval_top.f */
src/cbpe_pkg.sv
src/cbpe_div.sv
src/cbpe_weights.sv
src/cbpe_mac.sv
src/cubic_bezier_point_eval_top.sv
tb/tb_top.sv
